[hw/rtl/rollback_union_find_macros.svh]
// Assertion macros for the rollback union-find block.
// RUF_ASSERT_IMP checks a same-cycle implication, RUF_ASSERT_NXT a next-cycle one.
`ifndef ROLLBACK_UNION_FIND_MACROS_SVH
`define ROLLBACK_UNION_FIND_MACROS_SVH
`ifndef SYNTHESIS
`define RUF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rollback_union_find: check failed");
`define RUF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rollback_union_find: check failed");
`else
`define RUF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RUF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/ruf_pkg.sv]
package ruf_pkg;

  localparam int NODE_W        = 11;
  localparam int MAX_NODES_DEF = 1024;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } ruf_status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK_A,
    S_WALK_B,
    S_LINK,
    S_POP,
    S_UNDO_C,
    S_UNDO_R,
    S_UNDO_WR,
    S_RESP
  } ruf_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_WALK_A,
    OP_WALK_B,
    OP_LINK,
    OP_POP,
    OP_UNDO_C,
    OP_UNDO_R,
    OP_UNDO_WR,
    OP_RESULT
  } ruf_op_t;

  // controller -> datapath
  typedef struct packed {
    ruf_op_t     op;
    ruf_status_t res;
  } ruf_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;
    logic root_hit;
    logic depth_zero;
    logic clr_last;
    logic out_free;
  } ruf_sts_t;

endpackage

[hw/rtl/ruf_ctrl.sv]
module ruf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_tvalid,
  input  logic              in_kind,
  input  ruf_pkg::ruf_sts_t sts,
  output logic              in_tready,
  output ruf_pkg::ruf_ctl_t ctl
);

  ruf_pkg::ruf_state_t  state_r, state_nxt;
  ruf_pkg::ruf_status_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ruf_pkg::S_CLEAR;
      res_r   <= ruf_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    unique case (state_r)
      ruf_pkg::S_CLEAR: begin
        if (sts.clr_last) state_nxt = ruf_pkg::S_IDLE;
      end
      ruf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          res_nxt = ruf_pkg::ST_OK;
          if (in_kind) begin
            if (sts.depth_zero) begin
              res_nxt   = ruf_pkg::ST_EMPTY;
              state_nxt = ruf_pkg::S_RESP;
            end else begin
              state_nxt = ruf_pkg::S_POP;
            end
          end else if (!sts.in_range) begin
            res_nxt   = ruf_pkg::ST_RANGE;
            state_nxt = ruf_pkg::S_RESP;
          end else begin
            state_nxt = ruf_pkg::S_WALK_A;
          end
        end
      end
      ruf_pkg::S_WALK_A: begin
        if (sts.root_hit) state_nxt = ruf_pkg::S_WALK_B;
      end
      ruf_pkg::S_WALK_B: begin
        if (sts.root_hit) state_nxt = ruf_pkg::S_LINK;
      end
      ruf_pkg::S_LINK:    state_nxt = ruf_pkg::S_RESP;
      ruf_pkg::S_POP:     state_nxt = ruf_pkg::S_UNDO_C;
      ruf_pkg::S_UNDO_C:  state_nxt = ruf_pkg::S_UNDO_R;
      ruf_pkg::S_UNDO_R:  state_nxt = ruf_pkg::S_UNDO_WR;
      ruf_pkg::S_UNDO_WR: state_nxt = ruf_pkg::S_RESP;
      ruf_pkg::S_RESP: begin
        if (sts.out_free) state_nxt = ruf_pkg::S_IDLE;
      end
      default: state_nxt = ruf_pkg::S_IDLE;
    endcase
    // a node_count write restarts the clearing sweep
    if (cfg_we) state_nxt = ruf_pkg::S_CLEAR;
  end

  // outputs
  always_comb begin
    ctl.res   = res_r;
    ctl.op    = ruf_pkg::OP_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      ruf_pkg::S_CLEAR: ctl.op = ruf_pkg::OP_CLEAR;
      ruf_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) ctl.op = ruf_pkg::OP_LOAD;
      end
      ruf_pkg::S_WALK_A:  ctl.op = ruf_pkg::OP_WALK_A;
      ruf_pkg::S_WALK_B:  ctl.op = ruf_pkg::OP_WALK_B;
      ruf_pkg::S_LINK:    ctl.op = ruf_pkg::OP_LINK;
      ruf_pkg::S_POP:     ctl.op = ruf_pkg::OP_POP;
      ruf_pkg::S_UNDO_C:  ctl.op = ruf_pkg::OP_UNDO_C;
      ruf_pkg::S_UNDO_R:  ctl.op = ruf_pkg::OP_UNDO_R;
      ruf_pkg::S_UNDO_WR: ctl.op = ruf_pkg::OP_UNDO_WR;
      ruf_pkg::S_RESP: begin
        if (sts.out_free) ctl.op = ruf_pkg::OP_RESULT;
      end
      default: ctl.op = ruf_pkg::OP_NONE;
    endcase
  end

endmodule

[hw/rtl/ruf_dp.sv]
module ruf_dp #(
  parameter int MAX_NODES = ruf_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ruf_pkg::NODE_W-1:0]      cfg_wdata,
  input  logic [ruf_pkg::NODE_W-1:0]      in_node_a,
  input  logic [ruf_pkg::NODE_W-1:0]      in_node_b,
  input  ruf_pkg::ruf_ctl_t               ctl,
  output ruf_pkg::ruf_sts_t               sts,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [ruf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int NW    = ruf_pkg::NODE_W;
  localparam int AW    = $clog2(MAX_NODES + 1);   // node address / set size
  localparam int DW    = $clog2(MAX_NODES + 1);   // stack depth
  localparam int SW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int NC_RST = (MAX_NODES > (2 ** NW) - 1) ? (2 ** NW) - 1 : MAX_NODES;
  localparam int PAD_W = ruf_pkg::OUT_TDATA_W - NW - 3;

  logic [AW-1:0]   par_mem  [0:MAX_NODES];
  logic [AW-1:0]   size_mem [0:MAX_NODES];
  logic [2*AW-1:0] stk_mem  [0:MAX_NODES-1];

  logic [AW-1:0]   par_rd, size_rd;
  logic [2*AW-1:0] stk_rd;

  logic [AW-1:0]   x_r, x_nxt;
  logic [AW-1:0]   nb_r;
  logic [AW-1:0]   ra_r, sa_r, rb_r, sb_r;
  logic [AW-1:0]   cc_r;
  logic [DW-1:0]   depth_r, depth_dec;
  logic [NW-1:0]   comp_r, node_count_r, ncnt_clamp;
  logic [AW-1:0]   clr_r;
  logic            merged_r;
  logic            out_valid_r;
  logic [ruf_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic            root_hit, link_ok, a_big;
  logic [AW-1:0]   big, sub_root;
  logic [AW-1:0]   stk_child, stk_root;
  logic            par_we, size_we;
  logic [AW-1:0]   par_wa, par_wd, size_wa, size_wd;

  assign root_hit   = (par_rd == x_r);
  assign depth_dec  = depth_r - DW'(1);
  assign a_big      = !(sa_r < sb_r);
  assign big        = a_big ? ra_r : rb_r;
  assign sub_root   = a_big ? rb_r : ra_r;
  assign link_ok    = (ra_r != rb_r) && (depth_r < DW'(MAX_NODES));
  assign stk_child  = stk_rd[2*AW-1:AW];
  assign stk_root   = stk_rd[AW-1:0];

  // clamp the written node count to 1..MAX_NODES
  always_comb begin
    ncnt_clamp = cfg_wdata;
    if (cfg_wdata == '0) ncnt_clamp = NW'(1);
    else if (32'(cfg_wdata) > MAX_NODES) ncnt_clamp = NW'(MAX_NODES);
  end

  always_comb begin
    sts.in_range   = (in_node_a != '0) && (in_node_a <= node_count_r) &&
                     (in_node_b != '0) && (in_node_b <= node_count_r);
    sts.root_hit   = root_hit;
    sts.depth_zero = (depth_r == '0);
    sts.clr_last   = (clr_r == AW'(MAX_NODES));
    sts.out_free   = !out_valid_r || out_tready;
  end

  // shared read address for parent and size: the data seen next cycle
  // always belongs to x_r
  always_comb begin
    x_nxt = x_r;
    case (ctl.op)
      ruf_pkg::OP_LOAD:   x_nxt = AW'(in_node_a);
      ruf_pkg::OP_WALK_A: x_nxt = root_hit ? nb_r : par_rd;
      ruf_pkg::OP_WALK_B: x_nxt = par_rd;
      ruf_pkg::OP_UNDO_C: x_nxt = stk_child;
      ruf_pkg::OP_UNDO_R: x_nxt = stk_root;
      default:            x_nxt = x_r;
    endcase
  end

  always_comb begin
    par_we  = 1'b0;
    par_wa  = clr_r;
    par_wd  = clr_r;
    size_we = 1'b0;
    size_wa = clr_r;
    size_wd = AW'(1);
    case (ctl.op)
      ruf_pkg::OP_CLEAR: begin
        par_we  = 1'b1;
        size_we = 1'b1;
      end
      ruf_pkg::OP_LINK: begin
        par_we  = link_ok;
        par_wa  = sub_root;
        par_wd  = big;
        size_we = link_ok;
        size_wa = big;
        size_wd = sa_r + sb_r;
      end
      ruf_pkg::OP_UNDO_WR: begin
        par_we  = 1'b1;
        par_wa  = cc_r;
        par_wd  = cc_r;
        size_we = 1'b1;
        size_wa = stk_root;
        size_wd = size_rd - sa_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd <= par_mem[x_nxt];
  end

  always_ff @(posedge clk) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    size_rd <= size_mem[x_nxt];
  end

  always_ff @(posedge clk) begin
    if (ctl.op == ruf_pkg::OP_LINK && link_ok) stk_mem[depth_r[SW-1:0]] <= {sub_root, big};
    if (ctl.op == ruf_pkg::OP_POP) stk_rd <= stk_mem[depth_dec[SW-1:0]];
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (ctl.op == ruf_pkg::OP_LOAD) nb_r <= AW'(in_node_b);
    if (ctl.op == ruf_pkg::OP_WALK_A && root_hit) begin
      ra_r <= x_r;
      sa_r <= size_rd;
    end
    if (ctl.op == ruf_pkg::OP_WALK_B && root_hit) begin
      rb_r <= x_r;
      sb_r <= size_rd;
    end
    if (ctl.op == ruf_pkg::OP_UNDO_C) cc_r <= stk_child;
    if (ctl.op == ruf_pkg::OP_UNDO_R) sa_r <= size_rd;
    if (ctl.op == ruf_pkg::OP_RESULT) out_data_r <= {{PAD_W{1'b0}}, comp_r, ctl.res, merged_r};
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NW'(NC_RST);
      comp_r       <= NW'(NC_RST);
      depth_r      <= '0;
      clr_r        <= '0;
      merged_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (ctl.op == ruf_pkg::OP_RESULT) out_valid_r <= 1'b1;
      else if (out_tready)              out_valid_r <= 1'b0;
      if (cfg_we) begin
        node_count_r <= ncnt_clamp;
        comp_r       <= ncnt_clamp;
        depth_r      <= '0;
        clr_r        <= '0;
      end else begin
        case (ctl.op)
          ruf_pkg::OP_CLEAR: clr_r <= clr_r + AW'(1);
          ruf_pkg::OP_LOAD:  merged_r <= 1'b0;
          ruf_pkg::OP_LINK: begin
            merged_r <= link_ok;
            if (link_ok) begin
              depth_r <= depth_r + DW'(1);
              comp_r  <= comp_r - NW'(1);
            end
          end
          ruf_pkg::OP_POP:     depth_r <= depth_dec;
          ruf_pkg::OP_UNDO_WR: comp_r  <= comp_r + NW'(1);
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/rollback_union_find.sv]
// Channel   Dir  Beat contents (lowest bit first)
// in_       in   tuser: kind; tdata: node_a[10:0], node_b[21:11], zero pad [23:22]
// out_      out  tdata: merged[0], status[2:1], component_count[13:3], zero pad
// cfg_      in   cfg_we / cfg_wdata: node_count, written on any edge with cfg_we high
//
// One beat in flight at a time. A link walks from each of its two nodes up to
// the root, hA and hB being the tree heights above the two nodes (at most
// log2(MAX_NODES) each); the cost is one parent-memory read per step of each
// root walk. An undo pops the stack, reads the child and root entries and writes
// both memories back; an out-of-range link or an empty undo goes straight to its
// result. After reset and after every node_count write, a clearing pass rewrites
// the parent and size memories while in_tready stays low. The result sits in an
// output register; a stalled out_ side holds only the finishing item, not the walk.
`include "rollback_union_find_macros.svh"

module rollback_union_find #(
  parameter int MAX_NODES = ruf_pkg::MAX_NODES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // node_count
  input  logic                            cfg_we,
  input  logic [ruf_pkg::NODE_W-1:0]      cfg_wdata,
  // in: tuser = kind (0 link, 1 undo)
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic                            in_tuser,
  // in: tdata = node_a [10:0], node_b [21:11], pad [23:22]
  input  logic [ruf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out: tdata = merged [0], status [2:1], component_count [13:3], pad [15:14]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ruf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int NW = ruf_pkg::NODE_W;

  ruf_pkg::ruf_ctl_t ctl;
  ruf_pkg::ruf_sts_t sts;
  logic [NW-1:0]     in_node_a, in_node_b;

  // unpack the input beat
  assign in_node_a = in_tdata[NW-1:0];
  assign in_node_b = in_tdata[2*NW-1:NW];

  // sequencer: walk, link, undo and result steps
  ruf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_tvalid (in_tvalid),
    .in_kind   (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  // parent / size memories, undo stack, counters and output register
  ruf_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_node_a  (in_node_a),
    .in_node_b  (in_node_b),
    .ctl        (ctl),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // an accepted beat blocks the next one until its result is loaded
  `RUF_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // a node_count write starts the clearing pass
  `RUF_ASSERT_NXT(a_cfg_clears, clk, rst_n, cfg_we, !in_tready)
  // there is always at least one set
  `RUF_ASSERT_IMP(a_comp_nonzero, clk, rst_n, out_tvalid, out_tdata[NW+2:3] != '0)
  // a merge is only reported with an ok status
  `RUF_ASSERT_IMP(a_merged_ok, clk, rst_n, out_tvalid && out_tdata[0],
    out_tdata[2:1] == ruf_pkg::ST_OK)

endmodule

[test/rollback_union_find_test.sv]
`timescale 1ns / 1ps

module rollback_union_find_test;

  localparam int  NODES     = ruf_pkg::MAX_NODES_DEF;
  localparam bit  KIND_LINK = 1'b0;
  localparam bit  KIND_UNDO = 1'b1;
  localparam int  SETTLE    = 40;  // longer than the slowest link walk

  typedef struct {
    bit        kind;
    bit [10:0] node_a;
    bit [10:0] node_b;
  } uf_req_t;

  typedef struct {
    bit                   merged;
    ruf_pkg::ruf_status_t status;
    bit [10:0]            sets;
  } uf_resp_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [ruf_pkg::NODE_W-1:0]      cfg_wdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic                            in_tuser;     // kind
  logic [ruf_pkg::IN_TDATA_W-1:0]  in_tdata;     // node_a, node_b, zero pad
  logic                            out_tvalid;
  logic                            out_tready;
  logic [ruf_pkg::OUT_TDATA_W-1:0] out_tdata;    // merged, status, component_count, zero pad

  rollback_union_find u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the disjoint-set store, kept in step with accepted beats.
  int uf_parent [0:NODES];
  int uf_size   [0:NODES];
  int undo_child[0:NODES-1];
  int undo_root [0:NODES-1];
  int undo_top;
  int live_sets;
  int node_limit;

  uf_req_t  pending_ops[$];
  uf_resp_t expected_results[$];
  int       mismatches;

  // Pacing state for both sides; calm mode means back-to-back beats.
  int in_gap;
  int out_wait;
  bit in_calm;
  bit out_calm;
  bit in_taken;

  // Put every node back in a set of its own and empty the undo stack.
  function automatic void reset_sets();
    for (int i = 0; i <= NODES; i++) begin
      uf_parent[i] = i;
      uf_size[i]   = 1;
    end
    undo_top  = 0;
    live_sets = node_limit;
  endfunction

  // Clamp the register value into 1..NODES the way the block does.
  function automatic void load_node_count(bit [10:0] value);
    int v;
    v = value;
    if (v < 1) v = 1;
    if (v > NODES) v = NODES;
    node_limit = v;
    reset_sets();
  endfunction

  // Walk parent links up to the root; no compression, bounded step count.
  function automatic int find_set_root(int node);
    int x;
    int steps;
    x = node;
    steps = 0;
    while (uf_parent[x] != x && steps < NODES) begin
      x = uf_parent[x];
      if (x > NODES) x = 0;
      steps++;
    end
    return x;
  endfunction

  // Apply one beat to the shadow store and return the result it must produce.
  function automatic uf_resp_t predict_beat(uf_req_t req);
    uf_resp_t res;
    int ra;
    int rb;
    int hi_root;
    int lo_root;
    int child;
    int parent;
    res.merged = 1'b0;
    res.status = ruf_pkg::ST_OK;
    if (req.kind == KIND_UNDO) begin
      if (undo_top == 0) begin
        res.status = ruf_pkg::ST_EMPTY;
      end else begin
        undo_top--;
        child  = undo_child[undo_top];
        parent = undo_root[undo_top];
        uf_parent[child] = child;
        uf_size[parent] -= uf_size[child];
        live_sets++;
      end
    end else if (req.node_a < 1 || req.node_a > node_limit ||
                 req.node_b < 1 || req.node_b > node_limit) begin
      res.status = ruf_pkg::ST_RANGE;
    end else begin
      ra = find_set_root(req.node_a);
      rb = find_set_root(req.node_b);
      if (ra != rb && undo_top < NODES) begin
        // equal sizes keep node_a's root on top
        hi_root = ra;
        lo_root = rb;
        if (uf_size[ra] < uf_size[rb]) begin
          hi_root = rb;
          lo_root = ra;
        end
        uf_parent[lo_root] = hi_root;
        uf_size[hi_root] += uf_size[lo_root];
        undo_child[undo_top] = lo_root;
        undo_root[undo_top]  = hi_root;
        undo_top++;
        live_sets--;
        res.merged = 1'b1;
      end
    end
    res.sets = live_sets[10:0];
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Input driver: present a beat at the falling edge, hold it until taken.
  always @(negedge clk) begin
    uf_req_t cur;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the beat until the block takes it
    end else if (in_gap > 0) begin
      in_gap--;
      in_tvalid <= 1'b0;
    end else if (pending_ops.size() > 0) begin
      cur = pending_ops.pop_front();
      in_tuser  <= cur.kind;
      in_tdata  <= {2'b00, cur.node_b, cur.node_a};
      in_tvalid <= 1'b1;
      if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      in_gap = in_calm ? 0 : $urandom_range(0, 19);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Input side capture: every accepted beat runs through the predictor.
  always @(posedge clk) begin
    uf_req_t req;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      req.kind   = in_tuser;
      req.node_a = in_tdata[10:0];
      req.node_b = in_tdata[21:11];
      expected_results = {expected_results, predict_beat(req)};
    end
  end

  // Result side backpressure: stall a drawn number of cycles after each beat.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_wait > 0) begin
      out_wait--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Result monitor: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    uf_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      out_wait = out_calm ? 0 : $urandom_range(0, 19);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual tdata %h",
                 $time, out_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[0] !== want.merged) begin
          $display("%0t: merged expected %0d actual %0d", $time, want.merged, out_tdata[0]);
          mismatches++;
        end
        if (out_tdata[2:1] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_tdata[2:1]);
          mismatches++;
        end
        if (out_tdata[13:3] !== want.sets) begin
          $display("%0t: component_count expected %0d actual %0d", $time, want.sets,
                   out_tdata[13:3]);
          mismatches++;
        end
      end
    end
  end

  task automatic queue_link(int a, int b);
    uf_req_t req;
    req.kind   = KIND_LINK;
    req.node_a = a[10:0];
    req.node_b = b[10:0];
    pending_ops = {pending_ops, req};
  endtask

  task automatic queue_undo();
    uf_req_t req;
    req.kind   = KIND_UNDO;
    req.node_a = $urandom_range(0, 2047);
    req.node_b = $urandom_range(0, 2047);
    pending_ops = {pending_ops, req};
  endtask

  // Hold off the sender until every predicted result has come back.
  // Check at the rising edge, where the driven beat has settled.
  task automatic wait_all_results();
    while (pending_ops.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_node_count(int value);
    @(negedge clk);
    cfg_wdata <= value[10:0];
    cfg_we    <= 1'b1;
    load_node_count(value[10:0]);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pair up equal-size blocks level by level so trees reach full height.
  task automatic build_balanced(int leaves);
    int a;
    int b;
    for (int span = 1; span < leaves; span *= 2) begin
      for (int blk = 0; blk < leaves; blk += 2 * span) begin
        a = 1 + blk + $urandom_range(0, span - 1);
        b = 1 + blk + span + $urandom_range(0, span - 1);
        if ($urandom_range(0, 1)) queue_link(a, b);
        else queue_link(b, a);
      end
    end
  endtask

  // Mostly in-range links, a share of undos, the rest out-of-range noise.
  task automatic random_mix(int count, int undo_pct);
    int r;
    int a;
    int b;
    int bad;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      a = $urandom_range(1, node_limit);
      b = $urandom_range(1, node_limit);
      if (r < undo_pct) begin
        queue_undo();
      end else if (r < undo_pct + 12) begin
        bad = (node_limit < 2047 && $urandom_range(0, 2) != 0) ?
              $urandom_range(node_limit + 1, 2047) : 0;
        if ($urandom_range(0, 1)) queue_link(bad, b);
        else queue_link(a, bad);
      end else begin
        queue_link(a, b);
      end
    end
  endtask

  initial begin
    int sizes[5];
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tuser   = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    in_gap     = 0;
    out_wait   = 0;
    in_calm    = 1'b0;
    out_calm   = 1'b0;
    in_taken   = 1'b0;
    mismatches = 0;
    node_limit = NODES;
    reset_sets();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: range edges, self link, same set, equal and unequal sizes,
    // empty undo, undo carrying junk node fields.
    queue_link(0, 5);
    queue_link(5, 0);
    queue_link(1025, 3);
    queue_link(3, 2047);
    queue_undo();
    queue_link(7, 7);
    queue_link(1, 1024);
    queue_link(1024, 1);
    queue_link(2, 3);
    queue_link(3, 1);
    queue_link(5, 2);
    queue_link(1023, 1024);
    queue_undo();
    queue_undo();
    queue_undo();
    queue_undo();
    queue_undo();
    queue_link(1024, 1023);
    queue_link(1024, 1024);
    wait_all_results();

    // A zero write clamps to a single node.
    write_node_count(0);
    queue_link(1, 1);
    queue_link(1, 2);
    queue_link(2047, 2047);
    queue_undo();
    wait_all_results();

    write_node_count(2);
    queue_link(2, 1);
    queue_link(1, 2);
    queue_link(2, 3);
    queue_undo();
    queue_link(1, 2);
    wait_all_results();

    // Oversized write clamps to the full store; grow deep trees, unwind them.
    write_node_count(2047);
    build_balanced(256);
    random_mix(40, 0);
    wait_all_results();
    for (int i = 0; i < 40; i++) queue_undo();
    random_mix(60, 20);
    wait_all_results();

    sizes[0] = 16;
    sizes[1] = 5;
    sizes[2] = 64;
    sizes[3] = $urandom_range(100, 900);
    sizes[4] = 1024;
    foreach (sizes[k]) begin
      write_node_count(sizes[k]);
      random_mix(90, 15);
      wait_all_results();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAILURE");
    $finish;
  end

endmodule
